>>> rtl/kks_pkg.sv
package kks_pkg;

  // Variances, noise registers and the configuration port are 32 bits wide
  localparam int VAR_W             = 32;
  localparam int PROD_W            = 2 * VAR_W;
  localparam int CFG_IDX_W         = 2;

  localparam int ANGLE_WIDTH_DEF   = 32;
  localparam int VAR_FRAC_BITS_DEF = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE    = 2'd0,
    REG_MEASURE_NOISE    = 2'd1,
    REG_INITIAL_VARIANCE = 2'd2
  } kks_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIVGO,
    ST_DIV,
    ST_MLO,
    ST_MHI,
    ST_MP,
    ST_CORR,
    ST_UPD,
    ST_OUT
  } kks_state_t;

endpackage

>>> rtl/kks_div.sv
module kks_div #(
  parameter int VAR_FRAC_BITS = kks_pkg::VAR_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [kks_pkg::VAR_W-1:0]       dividend,
  input  logic [kks_pkg::VAR_W-1:0]       divisor,
  output logic [VAR_FRAC_BITS:0]          quo,
  output logic                            last
);
  import kks_pkg::*;

  localparam int K_W   = VAR_FRAC_BITS + 1;
  localparam int CNT_W = $clog2(K_W + 1);

  logic [VAR_W-1:0] rem_r;
  logic [VAR_W-1:0] den_r;
  logic [K_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             first_r;

  logic [VAR_W:0]   shifted;
  logic [VAR_W:0]   trial;
  logic             ge;
  logic [VAR_W-1:0] rem_nxt;

  // Restoring division, one quotient bit per cycle. The first step takes the
  // integer bit (dividend never exceeds divisor), the rest the fraction bits.
  always_comb begin
    shifted = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    trial   = shifted - {1'b0, den_r};
    ge      = (den_r != '0) && (shifted >= {1'b0, den_r});
    rem_nxt = ge ? trial[VAR_W-1:0] : shifted[VAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else if (start) begin
      busy_r  <= 1'b1;
      first_r <= 1'b1;
      cnt_r   <= CNT_W'(K_W);
      rem_r   <= dividend;
      den_r   <= divisor;
      quo_r   <= '0;
    end else if (busy_r) begin
      first_r <= 1'b0;
      cnt_r   <= cnt_r - 1'b1;
      rem_r   <= rem_nxt;
      quo_r   <= {quo_r[K_W-2:0], ge};
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign last = busy_r && (cnt_r == CNT_W'(1));
  assign quo  = quo_r;

endmodule

>>> rtl/kks_mul.sv
module kks_mul (
  input  logic                        clk,
  input  logic [kks_pkg::VAR_W-1:0]   mul_a,
  input  logic [kks_pkg::VAR_W-1:0]   mul_b,
  output logic [kks_pkg::PROD_W-1:0]  prod
);
  import kks_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // One registered 32x32 product per cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

>>> rtl/dual_axis_kalman_smoother.sv
// Channel   Dir  Handshake             Payload
// in_       in   in_tvalid/in_tready   in_tdata: pitch_meas, yaw_meas
// out_      out  out_tvalid/out_tready out_tdata: pitch_est, yaw_est
// cfg_      in   cfg_wr_en             cfg_index, cfg_wdata
//
// The first item after reset only loads the state.
// For each later item, per axis, one shared restoring divider computes
// the gain, then one shared 32x32 multiplier runs three products.
// Reset (rst_n low, synchronous) clears the sequencer, the primed flag and
// the output valid, and loads q, r and the initial variance with their defaults.
// in_tready is high only while the sequencer is idle; a result that waits on
// out_tready holds in the output register and does not block the next item.
module dual_axis_kalman_smoother #(
  parameter int ANGLE_WIDTH   = kks_pkg::ANGLE_WIDTH_DEF,
  parameter int VAR_FRAC_BITS = kks_pkg::VAR_FRAC_BITS_DEF,
  localparam int DATA_W       = ((2 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [DATA_W-1:0]                in_tdata,   // pitch_meas, yaw_meas
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [DATA_W-1:0]                out_tdata,  // pitch_est, yaw_est
  input  logic                             cfg_wr_en,
  input  logic [kks_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kks_pkg::VAR_W-1:0]        cfg_wdata
);
  import kks_pkg::*;

  localparam int AW  = ANGLE_WIDTH;
  localparam int F   = VAR_FRAC_BITS;
  localparam int K_W = F + 1;

  // Defaults: q = 0.001, r = 0.5, initial variance = 0.1, rounded
  localparam logic [63:0] VAR_ONE   = 64'd1 << F;
  localparam logic [VAR_W-1:0] Q_RST = VAR_W'((VAR_ONE + 64'd500) / 64'd1000);
  localparam logic [VAR_W-1:0] R_RST = VAR_W'(VAR_ONE >> 1);
  localparam logic [VAR_W-1:0] V_RST = VAR_W'((VAR_ONE + 64'd5) / 64'd10);
  localparam logic [K_W-1:0]   K_ONE = {1'b1, {F{1'b0}}};

  kks_state_t state_r, state_nxt;

  logic [VAR_W-1:0]    q_r, r_r, v0_r;
  logic                primed_r;
  logic signed [AW-1:0] x_r [2];
  logic signed [AW-1:0] z_r [2];
  logic [VAR_W-1:0]    p_r [2];
  logic                axis_r;
  logic [VAR_W-1:0]    pe_r;
  logic [AW-1:0]       mag_r;
  logic                neg_r;
  logic [PROD_W-1:0]   plo_r, phi_r;
  logic [AW-1:0]       corr_r;
  logic                out_tvalid_r;
  logic [DATA_W-1:0]   out_tdata_r;

  logic [VAR_W:0]      pe_sum, den_sum;
  logic [VAR_W-1:0]    pe_sat, den_sat;
  logic signed [AW:0]  diff;
  logic [AW:0]         diff_abs;
  logic [PROD_W-1:0]   mag64;
  logic [PROD_W-1:0]   corr64;
  logic signed [AW:0]  x_upd;
  logic [VAR_W-1:0]    p_new;
  logic                in_xfer;
  logic                out_load;

  logic                div_start;
  logic                div_last;
  logic [K_W-1:0]      k;
  logic [VAR_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_prod;

  kks_div #(.VAR_FRAC_BITS(VAR_FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pe_r),
    .divisor  (den_sat),
    .quo      (k),
    .last     (div_last)
  );

  kks_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (mul_prod)
  );

  // Datapath around the shared units
  always_comb begin
    // saturating p + q and p_est + r
    pe_sum   = {1'b0, p_r[axis_r]} + {1'b0, q_r};
    pe_sat   = pe_sum[VAR_W] ? '1 : pe_sum[VAR_W-1:0];
    den_sum  = {1'b0, pe_r} + {1'b0, r_r};
    den_sat  = den_sum[VAR_W] ? '1 : den_sum[VAR_W-1:0];
    // innovation z - x and its magnitude
    diff     = {z_r[axis_r][AW-1], z_r[axis_r]} - {x_r[axis_r][AW-1], x_r[axis_r]};
    diff_abs = diff[AW] ? (AW+1)'(-diff) : diff;
    mag64    = PROD_W'(mag_r);
    // correction = |z - x| * k >> F, from the two partial products
    corr64   = (phi_r << (VAR_W - F)) + (plo_r >> F);
    x_upd    = neg_r ? ({x_r[axis_r][AW-1], x_r[axis_r]} - {1'b0, corr_r})
                     : ({x_r[axis_r][AW-1], x_r[axis_r]} + {1'b0, corr_r});
    // variance update = (1 - k) * p_est >> F
    p_new    = mul_prod[F+VAR_W-1:F];
  end

  assign in_xfer  = in_tvalid && in_tready;
  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid && primed_r) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV:   if (div_last) state_nxt = ST_MLO;
      ST_MLO:   state_nxt = ST_MHI;
      ST_MHI:   state_nxt = ST_MP;
      ST_MP:    state_nxt = ST_CORR;
      ST_CORR:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = axis_r ? ST_OUT : ST_PREP;
      ST_OUT:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and shared unit operands
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_DIVGO: div_start = 1'b1;
      ST_MLO: begin
        mul_a = mag64[VAR_W-1:0];
        mul_b = VAR_W'(k);
      end
      ST_MHI: begin
        mul_a = mag64[PROD_W-1:VAR_W];
        mul_b = VAR_W'(k);
      end
      ST_MP: begin
        mul_a = VAR_W'(K_ONE - k);
        mul_b = pe_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      primed_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      axis_r       <= 1'b0;
      q_r          <= Q_RST;
      r_r          <= R_RST;
      v0_r         <= V_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr_en) begin
        case (kks_reg_t'(cfg_index))
          REG_PROCESS_NOISE:    q_r  <= cfg_wdata;
          REG_MEASURE_NOISE:    r_r  <= cfg_wdata;
          REG_INITIAL_VARIANCE: v0_r <= cfg_wdata;
          default: ;  // unmapped index: drop the write
        endcase
      end

      // Hold the result until the downstream transfer completes
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (primed_r) begin
              z_r[0] <= in_tdata[AW-1:0];
              z_r[1] <= in_tdata[2*AW-1:AW];
              axis_r <= 1'b0;
            end else begin
              // first item: load state, emit nothing
              x_r[0]   <= in_tdata[AW-1:0];
              x_r[1]   <= in_tdata[2*AW-1:AW];
              p_r[0]   <= v0_r;
              p_r[1]   <= v0_r;
              primed_r <= 1'b1;
            end
          end
        end
        ST_PREP: begin
          pe_r  <= pe_sat;
          mag_r <= diff_abs[AW-1:0];
          neg_r <= diff[AW];
        end
        ST_MHI:  plo_r <= mul_prod;
        ST_MP:   phi_r <= mul_prod;
        ST_CORR: begin
          corr_r         <= corr64[AW-1:0];
          p_r[axis_r]    <= p_new;
        end
        ST_UPD: begin
          // estimate stays between x and z, so no overflow
          x_r[axis_r] <= x_upd[AW-1:0];
          axis_r      <= 1'b1;
        end
        ST_OUT: begin
          if (out_load) begin
            out_tdata_r <= DATA_W'({x_r[1], x_r[0]});
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> rtl/kks_chk.sv
module kks_chk #(
  parameter int DATA_W = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // A new result only appears while the input side is busy
  a_out_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared while input side was idle");

  // No result can come out of an item in the cycle right after its transfer
  a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !$rose(out_tvalid))
    else $error("result appeared right after input transfer");

endmodule

bind dual_axis_kalman_smoother kks_chk #(.DATA_W(DATA_W)) u_kks_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
